// ===== rtl/core/wce_pkg.sv =====
// Shared types and constants for the waveform column envelope block.
// Used by wce_mul and waveform_column_envelope_top.
`default_nettype none

package wce_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_WINDOW = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_addr;

    localparam int GAIN_W   = 16;
    localparam int WINDOW_W = 13;
    localparam int HEIGHT_W = 10;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd4096;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 13'd1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd256;

    localparam int GAIN_FRAC = 12;
    localparam int SUM_W     = 32;

    // shared multiplier: 32 x 16 bits
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_W   = MUL_A_W + MUL_B_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_ACC,
        S_MUL_P,
        S_DIV_P,
        S_WAIT_P,
        S_MUL_N,
        S_DIV_N,
        S_WAIT_N,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MUL_SEL_NONE,
        MUL_SEL_SAMPLE,
        MUL_SEL_POS,
        MUL_SEL_NEG
    } t_mul_sel;

    // sequencer controls for the datapath
    typedef struct packed {
        t_mul_sel mul_sel;
        logic     div_start;
    } t_seq_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/waveform_column_envelope_top.sv =====
// Waveform column envelope: per-window positive/negative averages turned into
// display rows. Depends on wce_pkg, wce_mul and wce_div.
//
// Input channel: i_in_valid / o_in_stall carry one signed sample per beat.
// Output channel: o_out_valid / i_out_stall carry one column (top and bottom
// row) per beat, once every samples_per_column samples.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_addr
// (0 gain, 1 samples per column, 2 column height); write only while idle.
//
// Each sample passes through capture, scaling on the shared multiplier and
// accumulation. The sample that closes a window then runs both sides through
// the shared multiplier and the bit-serial divider, which gives one quotient
// bit per cycle; a side with no samples skips its division. o_in_stall is
// high for the whole of that work.
// A finished column sits in the output register; new samples are taken while
// it waits. If a second column is ready before the first leaves, the block
// holds in its emit step with o_in_stall high until i_out_stall drops.
// Reset clears the accumulators, restores the register defaults and
// drops o_out_valid.
`default_nettype none

module waveform_column_envelope_top
    import wce_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic      [HEIGHT_W-1:0]    o_top_row,
    output logic      [HEIGHT_W-1:0]    o_bottom_row
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int QUO_W  = MUL_W - SAMPLE_BITS;

    // configuration registers
    logic [GAIN_W-1:0]   r_gain;
    logic [WINDOW_W-1:0] r_window;
    logic [HEIGHT_W-1:0] r_height;

    t_state   r_state, n_state;
    t_seq_ctl ctl;

    logic                   r_neg;
    logic [SAMPLE_BITS-1:0] r_abs;
    logic [SUM_W-1:0]       r_sum_p, r_sum_n;
    logic [CNT_W-1:0]       r_cnt_p, r_cnt_n, r_pos;
    logic [QUO_W-1:0]       r_off_p, r_off_n;
    logic                   r_out_valid;
    logic [HEIGHT_W-1:0]    r_top, r_bot;

    logic                   in_beat, out_beat;
    logic [SAMPLE_BITS-1:0] sample_u, abs_in;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [MUL_W-1:0]       prod;
    logic [SUM_W-1:0]       mag;
    logic [SUM_W:0]         add_sum;
    logic [SUM_W-1:0]       sat_sum;
    logic                   to_neg;
    logic [31:0]            win, pos_next;
    logic                   win_close;
    logic                   div_done;
    logic [QUO_W-1:0]       div_quot;
    logic [CNT_W-1:0]       div_den;
    logic                   out_free;
    logic [HEIGHT_W-1:0]    yc, top_row, bot_row;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign out_beat = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_window <= WINDOW_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_WINDOW: r_window <= i_cfg_data[WINDOW_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // magnitude of the sample; the most negative code yields 2^(SAMPLE_BITS-1)
    always_comb begin
        sample_u = i_sample;
        abs_in   = sample_u[SAMPLE_BITS-1] ? (~sample_u + SAMPLE_BITS'(1)) : sample_u;
    end

    always_comb begin
        case (ctl.mul_sel)
            MUL_SEL_SAMPLE: begin
                mul_a = MUL_A_W'(r_abs);
                mul_b = r_gain;
            end
            MUL_SEL_POS: begin
                mul_a = r_sum_p;
                mul_b = MUL_B_W'(r_height);
            end
            MUL_SEL_NEG: begin
                mul_a = r_sum_n;
                mul_b = MUL_B_W'(r_height);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    wce_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign div_den = (r_state == S_DIV_N) ? r_cnt_n : r_cnt_p;

    wce_div #(
        .NUM_W (QUO_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.div_start),
        .i_num   (prod[MUL_W-1:SAMPLE_BITS]),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // scaled magnitude, saturating accumulate, window close test
    always_comb begin
        mag     = (|prod[MUL_W-1:GAIN_FRAC+SUM_W]) ? '1 : prod[GAIN_FRAC+SUM_W-1:GAIN_FRAC];
        to_neg  = r_neg && (r_gain != '0);
        add_sum = {1'b0, to_neg ? r_sum_n : r_sum_p} + {1'b0, mag};
        sat_sum = add_sum[SUM_W] ? '1 : add_sum[SUM_W-1:0];

        if (r_window == '0) begin
            win = 32'd1;
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            win = 32'(MAX_WINDOW);
        end else begin
            win = 32'(r_window);
        end
        pos_next  = 32'(r_pos) + 32'd1;
        win_close = pos_next >= win;
    end

    // rows from the two offsets
    always_comb begin
        yc      = r_height >> 1;
        top_row = (r_off_p >= QUO_W'(yc)) ? '0 : HEIGHT_W'(yc - r_off_p[HEIGHT_W-1:0]);
        bot_row = (r_off_n >= QUO_W'(r_height - yc)) ?
                  r_height : HEIGHT_W'(yc + r_off_n[HEIGHT_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_beat) n_state = S_SCALE;
            S_SCALE:  n_state = S_ACC;
            S_ACC:    n_state = win_close ? S_MUL_P : S_IDLE;
            S_MUL_P:  n_state = S_DIV_P;
            S_DIV_P:  n_state = (r_cnt_p == '0) ? S_MUL_N : S_WAIT_P;
            S_WAIT_P: if (div_done) n_state = S_MUL_N;
            S_MUL_N:  n_state = S_DIV_N;
            S_DIV_N:  n_state = (r_cnt_n == '0) ? S_EMIT : S_WAIT_N;
            S_WAIT_N: if (div_done) n_state = S_EMIT;
            S_EMIT:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl.mul_sel   = MUL_SEL_NONE;
        ctl.div_start = 1'b0;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_SCALE: ctl.mul_sel = MUL_SEL_SAMPLE;
            S_MUL_P: ctl.mul_sel = MUL_SEL_POS;
            S_DIV_P: ctl.div_start = (r_cnt_p != '0);
            S_MUL_N: ctl.mul_sel = MUL_SEL_NEG;
            S_DIV_N: ctl.div_start = (r_cnt_n != '0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_neg <= sample_u[SAMPLE_BITS-1];
            r_abs <= abs_in;
        end
        // an empty side has offset zero
        if (r_state == S_DIV_P && r_cnt_p == '0) r_off_p <= '0;
        if (r_state == S_WAIT_P && div_done)     r_off_p <= div_quot;
        if (r_state == S_DIV_N && r_cnt_n == '0) r_off_n <= '0;
        if (r_state == S_WAIT_N && div_done)     r_off_n <= div_quot;
        if (r_state == S_EMIT && out_free) begin
            r_top <= top_row;
            r_bot <= bot_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_p     <= '0;
            r_sum_n     <= '0;
            r_cnt_p     <= '0;
            r_cnt_n     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ACC) begin
                r_pos <= r_pos + CNT_W'(1);
                if (to_neg) begin
                    r_sum_n <= sat_sum;
                    r_cnt_n <= r_cnt_n + CNT_W'(1);
                end else begin
                    r_sum_p <= sat_sum;
                    r_cnt_p <= r_cnt_p + CNT_W'(1);
                end
            end
            // hand the column over and clear the window
            if (r_state == S_EMIT && out_free) begin
                r_sum_p     <= '0;
                r_sum_n     <= '0;
                r_cnt_p     <= '0;
                r_cnt_n     <= '0;
                r_pos       <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_top_row    = r_top;
    assign o_bottom_row = r_bot;

endmodule

`default_nettype wire

// ===== rtl/core/wce_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on wce_pkg for operand widths.
`default_nettype none

module wce_mul
    import wce_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output logic      [MUL_W-1:0]   o_prod
);

    logic [MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_W'(i_a) * MUL_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/wce_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; the divisor must be non-zero.
`default_nettype none

module wce_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quot;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
        n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // numerator shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire
